@@ rtl/core/wss_pkg.sv @@
// wiper sweep sequencer package: field widths, mode and interval codes,
// configuration register indexes, reset values and knob thresholds
// no dependencies
package wss_pkg;

  localparam int PULSE_W  = 12;
  localparam int KNOB_W   = 12;
  localparam int STEP_T_W = 8;
  localparam int PAUSE_W  = 13;
  localparam int STEP_W   = 4;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 13;

  localparam int SWEEP_STEPS_DEF = 10;

  typedef enum logic [1:0] {
    MODE_OFF = 2'd0,
    MODE_INT = 2'd1,
    MODE_LO  = 2'd2,
    MODE_HI  = 2'd3
  } wss_mode_t;

  typedef enum logic [1:0] {
    IVL_SHORT = 2'd0,
    IVL_MED   = 2'd1,
    IVL_LONG  = 2'd2
  } wss_ivl_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HI_STEP     = 3'd0,
    CFG_LO_STEP     = 3'd1,
    CFG_SHORT_PAUSE = 3'd2,
    CFG_MED_PAUSE   = 3'd3,
    CFG_LONG_PAUSE  = 3'd4,
    CFG_PULSE_MIN   = 3'd5,
    CFG_PULSE_MAX   = 3'd6
  } wss_cfg_idx_t;

  localparam logic [STEP_T_W-1:0] HI_STEP_RST     = 8'd28;
  localparam logic [STEP_T_W-1:0] LO_STEP_RST     = 8'd37;
  localparam logic [PAUSE_W-1:0]  SHORT_PAUSE_RST = 13'd1200;
  localparam logic [PAUSE_W-1:0]  MED_PAUSE_RST   = 13'd2750;
  localparam logic [PAUSE_W-1:0]  LONG_PAUSE_RST  = 13'd4750;
  localparam logic [PULSE_W-1:0]  PULSE_MIN_RST   = 12'd800;
  localparam logic [PULSE_W-1:0]  PULSE_MAX_RST   = 12'd1470;

  // knob >= ceil(level * 4095 / 100) is the same as knob * 100 >= level * 4095
  localparam int KNOB_FULL = 4095;
  localparam logic [KNOB_W-1:0] THR_HI   = KNOB_W'((75 * KNOB_FULL + 99) / 100);
  localparam logic [KNOB_W-1:0] THR_LO   = KNOB_W'((50 * KNOB_FULL + 99) / 100);
  localparam logic [KNOB_W-1:0] THR_INT  = KNOB_W'((25 * KNOB_FULL + 99) / 100);
  localparam logic [KNOB_W-1:0] THR_LONG = KNOB_W'((66 * KNOB_FULL + 99) / 100);
  localparam logic [KNOB_W-1:0] THR_MED  = KNOB_W'((33 * KNOB_FULL + 99) / 100);

  // cycles from a register write until the step offset accumulators reload
  localparam logic [2:0] SETTLE_LEN = 3'd5;

endpackage

@@ rtl/core/wiper_sweep_sequencer_top.sv @@
// wiper sweep sequencer top level: knob classification, sweep and pause
// sequencing, incremental step offset and registered result stage
// depends on wss_pkg
//
//  port group | dir | transfer when          | payload
//  in         | in  | in_valid & in_ready    | engine_on, wiper_knob, interval_knob
//  out        | out | out_valid & out_ready  | servo_pulse_us, wiper_mode,
//             |     |                        | interval_choice, busy_res
//  cfg        | in  | cfg_valid & cfg_ready  | cfg_index, cfg_data
//
// one tick per cycle: each tick goes through short logic into the result register,
// and a tick is taken when no result waits or the waiting one transfers
// the step offset is kept as quotient and remainder and advanced by one add
// a register write or reset reloads it through a 4-stage reciprocal pipe,
// and ticks are held off until the reload is done; cfg_ready is always high
// reset is synchronous and resets config and sequencing state, not result payload
module wiper_sweep_sequencer_top import wss_pkg::*; #(
  parameter int SWEEP_STEPS = SWEEP_STEPS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  engine_on,
  input  logic [KNOB_W-1:0]     wiper_knob,
  input  logic [KNOB_W-1:0]     interval_knob,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [PULSE_W-1:0]    servo_pulse_us,
  output logic [1:0]            wiper_mode,
  output logic [1:0]            interval_choice,
  output logic                  busy_res,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int XW    = 16;
  localparam int SHIFT = 20;
  localparam int RECIP = (1 << SHIFT) / SWEEP_STEPS;
  localparam int HALF  = SWEEP_STEPS / 2;
  localparam int RW    = $clog2(2 * SWEEP_STEPS);
  localparam logic [STEP_W-1:0] STEP_N = STEP_W'(SWEEP_STEPS);
  localparam logic [RW:0]       REM_N  = (RW + 1)'(SWEEP_STEPS);
  localparam logic [RW-1:0]     REM_HALF = RW'(HALF);

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_SWEEP = 2'd1,
    PH_PAUSE = 2'd2
  } phase_t;

  // configuration registers
  logic [STEP_T_W-1:0] hi_step_ms, lo_step_ms;
  logic [PAUSE_W-1:0]  short_pause_ms, med_pause_ms, long_pause_ms;
  logic [PULSE_W-1:0]  pulse_min_us, pulse_max_us;

  // sequencing state
  phase_t              phase, phase_next;
  wss_mode_t           mode_reg, mode_next;
  wss_ivl_t            interval_reg, interval_next;
  logic                sweep_up, sweep_up_next;
  logic [STEP_W-1:0]   step_index, step_index_next;
  logic [STEP_T_W-1:0] hold_count, hold_count_next;
  logic [PAUSE_W-1:0]  pause_count, pause_count_next;
  logic [PULSE_W-1:0]  pulse_reg, pulse_next;

  // offset of the current step: (d * step_index + HALF) as quotient / remainder
  logic [XW-1:0]       acc_q, acc_q_next;
  logic [RW-1:0]       acc_r, acc_r_next;
  logic [XW-1:0]       step_q;
  logic [RW-1:0]       step_r;
  logic [2:0]          settle_cnt;

  logic in_xfer, cfg_xfer;

  assign cfg_ready = 1'b1;
  assign in_ready  = (settle_cnt == 3'd0) && (!out_valid || out_ready);
  assign in_xfer   = in_valid && in_ready;
  assign cfg_xfer  = cfg_valid && cfg_ready;

  // ---------------- reciprocal divide pipe, lane 0 d, lane 1 d*i+half
  logic                rising;
  logic [PULSE_W-1:0]  span;
  logic [1:0][XW-1:0]          num_s1, num_s2, q0_s3, quo_s4;
  logic [1:0][XW+SHIFT-1:0]    prod_s2;
  logic [1:0][RW:0]            rem_s3;
  logic [1:0][RW-1:0]          rem_s4;

  assign rising = pulse_max_us >= pulse_min_us;
  assign span   = rising ? pulse_max_us - pulse_min_us : pulse_min_us - pulse_max_us;

  always_ff @(posedge clk) begin
    num_s1[0] <= XW'(span);
    num_s1[1] <= XW'(XW'(span) * XW'(step_index)) + XW'(HALF);
    for (int i = 0; i < 2; i++) begin
      prod_s2[i] <= (XW + SHIFT)'(num_s1[i]) * (XW + SHIFT)'(RECIP);
      num_s2[i]  <= num_s1[i];
      q0_s3[i]   <= prod_s2[i][XW+SHIFT-1:SHIFT];
      rem_s3[i]  <= (RW + 1)'(num_s2[i] - XW'(prod_s2[i][XW+SHIFT-1:SHIFT] * XW'(SWEEP_STEPS)));
      if (rem_s3[i] >= REM_N) begin
        quo_s4[i] <= q0_s3[i] + XW'(1);
        rem_s4[i] <= RW'(rem_s3[i] - REM_N);
      end else begin
        quo_s4[i] <= q0_s3[i];
        rem_s4[i] <= RW'(rem_s3[i]);
      end
    end
  end

  // ---------------- per tick logic
  logic [RW:0]         adv_r_sum;
  logic                adv_carry;
  logic [XW-1:0]       adv_q;
  logic [RW-1:0]       adv_r;
  logic [STEP_T_W-1:0] hold_dec;
  logic [STEP_W-1:0]   step_inc;
  logic [PAUSE_W-1:0]  pause_dec;
  wss_mode_t           cls_mode;
  wss_ivl_t            cls_ivl;

  assign adv_r_sum = {1'b0, acc_r} + {1'b0, step_r};
  assign adv_carry = adv_r_sum >= REM_N;
  assign adv_r     = adv_carry ? RW'(adv_r_sum - REM_N) : RW'(adv_r_sum);
  assign adv_q     = acc_q + step_q + XW'(adv_carry);
  assign hold_dec  = hold_count - STEP_T_W'(1);
  assign step_inc  = step_index + STEP_W'(1);
  assign pause_dec = pause_count - PAUSE_W'(1);

  always_comb begin
    priority if (wiper_knob >= THR_HI)  cls_mode = MODE_HI;
    else if (wiper_knob >= THR_LO)      cls_mode = MODE_LO;
    else if (wiper_knob >= THR_INT)     cls_mode = MODE_INT;
    else                                cls_mode = MODE_OFF;
    priority if (interval_knob >= THR_LONG) cls_ivl = IVL_LONG;
    else if (interval_knob >= THR_MED)      cls_ivl = IVL_MED;
    else                                    cls_ivl = IVL_SHORT;
  end

  function automatic logic [STEP_T_W-1:0] step_time(input wss_mode_t m,
      input logic [STEP_T_W-1:0] hi_t, input logic [STEP_T_W-1:0] lo_t);
    logic [STEP_T_W-1:0] t;
    t = (m == MODE_HI) ? hi_t : lo_t;
    return (t == '0) ? STEP_T_W'(1) : t;
  endfunction

  function automatic logic [PAUSE_W-1:0] pause_time(input wss_ivl_t iv,
      input logic [PAUSE_W-1:0] s, input logic [PAUSE_W-1:0] m,
      input logic [PAUSE_W-1:0] l);
    logic [PAUSE_W-1:0] p;
    unique case (iv)
      IVL_SHORT: p = s;
      IVL_MED:   p = m;
      default:   p = l;
    endcase
    return (p == '0) ? PAUSE_W'(1) : p;
  endfunction

  function automatic logic [PULSE_W-1:0] pulse_at(input logic [XW-1:0] off,
      input logic up, input logic rise, input logic [PULSE_W-1:0] lo,
      input logic [PULSE_W-1:0] hi);
    logic [PULSE_W-1:0] o;
    o = off[PULSE_W-1:0];
    if (up) begin
      return rise ? lo + o : lo - o;
    end
    return rise ? hi - o : hi + o;
  endfunction

  always_comb begin
    phase_next       = phase;
    mode_next        = mode_reg;
    interval_next    = interval_reg;
    sweep_up_next    = sweep_up;
    step_index_next  = step_index;
    hold_count_next  = hold_count;
    pause_count_next = pause_count;
    pulse_next       = pulse_reg;
    acc_q_next       = acc_q;
    acc_r_next       = acc_r;
    if (!engine_on) begin
      phase_next       = PH_IDLE;
      step_index_next  = '0;
      hold_count_next  = '0;
      pause_count_next = '0;
      pulse_next       = pulse_min_us;
      acc_q_next       = '0;
      acc_r_next       = REM_HALF;
    end else begin
      unique case (phase)
        PH_SWEEP: begin
          hold_count_next = hold_dec;
          if (hold_dec == '0) begin
            if (step_inc >= STEP_N) begin
              step_index_next = '0;
              acc_q_next      = '0;
              acc_r_next      = REM_HALF;
              if (sweep_up) begin
                sweep_up_next = 1'b0;
                phase_next    = PH_IDLE;
              end else begin
                sweep_up_next = 1'b1;
                if (mode_reg == MODE_INT) begin
                  phase_next       = PH_PAUSE;
                  pause_count_next = pause_time(interval_reg, short_pause_ms,
                                                med_pause_ms, long_pause_ms);
                end else begin
                  phase_next = PH_IDLE;
                end
              end
            end else begin
              step_index_next = step_inc;
              acc_q_next      = adv_q;
              acc_r_next      = adv_r;
              pulse_next      = pulse_at(adv_q, sweep_up, rising, pulse_min_us,
                                         pulse_max_us);
              hold_count_next = step_time(mode_reg, hi_step_ms, lo_step_ms);
            end
          end
        end
        PH_PAUSE: begin
          mode_next        = cls_mode;
          interval_next    = cls_ivl;
          pause_count_next = pause_dec;
          if (pause_dec == '0) begin
            phase_next = PH_IDLE;
          end
        end
        default: begin
          mode_next     = cls_mode;
          interval_next = cls_ivl;
          phase_next    = PH_IDLE;
          if (cls_mode == MODE_OFF) begin
            pulse_next = pulse_min_us;
          end else begin
            phase_next      = PH_SWEEP;
            step_index_next = '0;
            acc_q_next      = '0;
            acc_r_next      = REM_HALF;
            pulse_next      = pulse_at('0, sweep_up, rising, pulse_min_us,
                                       pulse_max_us);
            hold_count_next = step_time(cls_mode, hi_step_ms, lo_step_ms);
          end
        end
      endcase
    end
  end

  // ---------------- registers
  always_ff @(posedge clk) begin
    if (rst) begin
      hi_step_ms     <= HI_STEP_RST;
      lo_step_ms     <= LO_STEP_RST;
      short_pause_ms <= SHORT_PAUSE_RST;
      med_pause_ms   <= MED_PAUSE_RST;
      long_pause_ms  <= LONG_PAUSE_RST;
      pulse_min_us   <= PULSE_MIN_RST;
      pulse_max_us   <= PULSE_MAX_RST;
      settle_cnt     <= SETTLE_LEN;
      phase          <= PH_IDLE;
      mode_reg       <= MODE_OFF;
      interval_reg   <= IVL_LONG;
      sweep_up       <= 1'b1;
      step_index     <= '0;
      hold_count     <= '0;
      pause_count    <= '0;
      pulse_reg      <= PULSE_MIN_RST;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_xfer) begin
        settle_cnt <= SETTLE_LEN;
        unique case (cfg_index)
          CFG_HI_STEP:     hi_step_ms     <= cfg_data[STEP_T_W-1:0];
          CFG_LO_STEP:     lo_step_ms     <= cfg_data[STEP_T_W-1:0];
          CFG_SHORT_PAUSE: short_pause_ms <= cfg_data;
          CFG_MED_PAUSE:   med_pause_ms   <= cfg_data;
          CFG_LONG_PAUSE:  long_pause_ms  <= cfg_data;
          CFG_PULSE_MIN:   pulse_min_us   <= cfg_data[PULSE_W-1:0];
          CFG_PULSE_MAX:   pulse_max_us   <= cfg_data[PULSE_W-1:0];
          default: ;
        endcase
      end else if (settle_cnt != 3'd0) begin
        settle_cnt <= settle_cnt - 3'd1;
      end
      if (in_xfer) begin
        phase           <= phase_next;
        mode_reg        <= mode_next;
        interval_reg    <= interval_next;
        sweep_up        <= sweep_up_next;
        step_index      <= step_index_next;
        hold_count      <= hold_count_next;
        pause_count     <= pause_count_next;
        pulse_reg       <= pulse_next;
        servo_pulse_us  <= pulse_next;
        wiper_mode      <= mode_next;
        interval_choice <= interval_next;
        busy_res        <= phase_next != PH_IDLE;
      end
      out_valid <= in_xfer || (out_valid && !out_ready);
    end
  end

  // offset accumulators
  always_ff @(posedge clk) begin
    if (settle_cnt == 3'd1) begin
      acc_q  <= quo_s4[1];
      acc_r  <= rem_s4[1];
      step_q <= quo_s4[0];
      step_r <= rem_s4[0];
    end else if (in_xfer) begin
      acc_q <= acc_q_next;
      acc_r <= acc_r_next;
    end
  end

  // ---------------- checks
  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    settle_cnt == 3'd0 |-> acc_r < RW'(SWEEP_STEPS))
    else $error("step offset remainder out of range");

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    step_index < STEP_N)
    else $error("step index past last step");

  a_hold_live: assert property (@(posedge clk) disable iff (rst)
    phase == PH_SWEEP |-> hold_count != '0)
    else $error("sweep step with zero hold time");

  a_cfg_blocks: assert property (@(posedge clk) disable iff (rst)
    cfg_xfer |=> !in_ready)
    else $error("tick taken before offset reload");

endmodule
